// ----- sv/aots_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package aots_pkg;

    // Default sizes of the table and of the coordinates.
    localparam int TABLE_DEPTH_DEF = 64;
    localparam int COORD_WIDTH_DEF = 16;

    // Fixed field widths.
    localparam int IDX_W = 6;
    localparam int DIM_W = 15;
    localparam int CNT_W = 32;
    localparam int REQ_W = 2;
    localparam int CFG_IDX_W = 2;

    // Result buffer of one query.
    localparam int MAX_RESULTS = 64;
    localparam int RES_AW = $clog2(MAX_RESULTS);
    localparam int RES_CW = $clog2(MAX_RESULTS + 1);

    // Command queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    // Request codes on the input word.
    localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_QUERY = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPORT_ALL = 2'd2;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_QUERY,
        OP_CLEAR
    } t_op;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } t_state;

    // Decoded command as it travels through the queue.
    typedef struct packed {
        t_op              op;
        logic             entry_en;
        logic [IDX_W-1:0] entry_idx;
        logic             excl_en;
        logic [IDX_W-1:0] excl_idx;
    } t_ctl;

    // Width of the signed compare path: holds position plus offset plus size.
    function automatic int ext_w(input int cw);
        return ((cw > DIM_W) ? cw : DIM_W) + 2;
    endfunction

    // Width of the coordinate payload: x, y, w, h, right edge, bottom edge.
    function automatic int pld_w(input int cw);
        return 2 * cw + 2 * DIM_W + 2 * ext_w(cw);
    endfunction

endpackage

`default_nettype wire

// ----- sv/aots_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none

module aots_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = aots_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    localparam int QAW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int QCW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [QAW-1:0]   r_wr_ptr;
    logic [QAW-1:0]   r_rd_ptr;
    logic [QCW-1:0]   r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == QCW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rd_ptr];

    // Storage for queued words.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QAW'(DEPTH - 1)) ? '0 : r_wr_ptr + QAW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QAW'(DEPTH - 1)) ? '0 : r_rd_ptr + QAW'(1);
            end
            unique case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + QCW'(1);
                2'b01:   r_cnt <= r_cnt - QCW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- sv/aots_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module aots_front #(
    parameter int TABLE_DEPTH = aots_pkg::TABLE_DEPTH_DEF,
    parameter int COORD_WIDTH = aots_pkg::COORD_WIDTH_DEF
) (
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [aots_pkg::REQ_W-1:0]            i_req_type,
    input  logic [aots_pkg::IDX_W-1:0]            i_entry_index,
    input  logic signed [COORD_WIDTH-1:0]         i_box_x,
    input  logic signed [COORD_WIDTH-1:0]         i_box_y,
    input  logic [aots_pkg::DIM_W-1:0]            i_box_w,
    input  logic [aots_pkg::DIM_W-1:0]            i_box_h,
    input  logic                                  i_entry_enable,
    input  logic                                  i_exclude_enable,
    input  logic [aots_pkg::IDX_W-1:0]            i_exclude_index,
    input  logic                                  i_full,
    input  logic                                  i_hold,
    output logic                                  o_push,
    output aots_pkg::t_ctl                        o_ctl,
    output logic [aots_pkg::pld_w(COORD_WIDTH)-1:0] o_pld
);

    localparam int EW = aots_pkg::ext_w(COORD_WIDTH);

    logic               accept;
    logic               in_range;
    logic               push_ok;
    aots_pkg::t_op      op;
    logic signed [EW-1:0] x_e;
    logic signed [EW-1:0] y_e;
    logic signed [EW-1:0] w_e;
    logic signed [EW-1:0] h_e;
    logic signed [EW-1:0] q_r;
    logic signed [EW-1:0] q_b;

    // The queue being full or the table clear pass holds the input off.
    assign o_in_stall = i_full || i_hold;
    assign accept     = i_in_valid && !o_in_stall;
    assign in_range   = (32'(i_entry_index) < 32'(TABLE_DEPTH));

    // Classify the request; unused codes and writes past the table are dropped.
    always_comb begin
        push_ok = 1'b0;
        op      = aots_pkg::OP_WRITE;
        unique case (i_req_type)
            aots_pkg::REQ_WRITE: begin
                push_ok = in_range;
                op      = aots_pkg::OP_WRITE;
            end
            aots_pkg::REQ_QUERY: begin
                push_ok = 1'b1;
                op      = aots_pkg::OP_QUERY;
            end
            aots_pkg::REQ_CLEAR: begin
                push_ok = 1'b1;
                op      = aots_pkg::OP_CLEAR;
            end
            default: begin
                push_ok = 1'b0;
            end
        endcase
    end

    assign o_push = accept && push_ok;

    // Right and bottom edges of the query box, wide enough not to wrap.
    assign x_e = EW'(i_box_x);
    assign y_e = EW'(i_box_y);
    assign w_e = EW'(i_box_w);
    assign h_e = EW'(i_box_h);
    assign q_r = x_e + w_e;
    assign q_b = y_e + h_e;

    assign o_ctl = '{
        op:        op,
        entry_en:  i_entry_enable,
        entry_idx: i_entry_index,
        excl_en:   i_exclude_enable,
        excl_idx:  i_exclude_index
    };

    assign o_pld = {i_box_x, i_box_y, i_box_w, i_box_h, q_r, q_b};

endmodule

`default_nettype wire

// ----- sv/aots_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module aots_back #(
    parameter int TABLE_DEPTH = aots_pkg::TABLE_DEPTH_DEF,
    parameter int COORD_WIDTH = aots_pkg::COORD_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cmd_valid,
    output logic                                  o_cmd_pop,
    input  aots_pkg::t_ctl                        i_ctl,
    input  logic [aots_pkg::pld_w(COORD_WIDTH)-1:0] i_pld,
    input  logic signed [COORD_WIDTH-1:0]         i_scroll_x,
    input  logic signed [COORD_WIDTH-1:0]         i_scroll_y,
    input  logic                                  i_report_all,
    output logic                                  o_clearing,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic                                  o_hit,
    output logic [aots_pkg::IDX_W-1:0]            o_hit_index,
    output logic                                  o_last,
    output logic [aots_pkg::CNT_W-1:0]            o_check_count
);

    localparam int CW    = COORD_WIDTH;
    localparam int EW    = aots_pkg::ext_w(COORD_WIDTH);
    localparam int DW    = aots_pkg::DIM_W;
    localparam int IW    = aots_pkg::IDX_W;
    localparam int NW    = aots_pkg::RES_CW;
    localparam int BAW   = aots_pkg::RES_AW;
    localparam int CNW   = aots_pkg::CNT_W;
    localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int PW    = $clog2(TABLE_DEPTH + 1);
    localparam int TW    = 2 * CW + 2 * DW + 1;
    // Payload layout from the front.
    localparam int P_QB  = 0;
    localparam int P_QR  = EW;
    localparam int P_H   = 2 * EW;
    localparam int P_W   = P_H + DW;
    localparam int P_Y   = P_W + DW;
    localparam int P_X   = P_Y + CW;
    // Table word layout, enable in bit zero.
    localparam int T_H   = 1;
    localparam int T_W   = T_H + DW;
    localparam int T_Y   = T_W + DW;
    localparam int T_X   = T_Y + CW;

    aots_pkg::t_state r_state;
    aots_pkg::t_state n_state;

    // Box table and scan pointer.
    logic [TW-1:0]        r_tab [TABLE_DEPTH];
    logic [TW-1:0]        r_tab_q;
    logic [PW-1:0]        r_ptr;

    // Scan pipeline.
    logic                 r_a_vld;
    logic [AW-1:0]        r_a_idx;
    logic                 r_b_test;
    logic [AW-1:0]        r_b_idx;
    logic signed [EW-1:0] r_b_ex;
    logic signed [EW-1:0] r_b_ey;
    logic [DW-1:0]        r_b_w;
    logic [DW-1:0]        r_b_h;

    // Query held during the scan.
    logic signed [EW-1:0] r_qx;
    logic signed [EW-1:0] r_qy;
    logic signed [EW-1:0] r_qr;
    logic signed [EW-1:0] r_qb;
    logic                 r_excl_en;
    logic [IW-1:0]        r_excl_idx;

    // Hit buffer and its readout.
    logic [IW-1:0]        r_rbuf [aots_pkg::MAX_RESULTS];
    logic [NW-1:0]        r_n;
    logic [NW-1:0]        r_rd_ptr;
    logic                 r_rd_vld;
    logic [IW-1:0]        r_rd_data;
    logic                 r_rd_last;

    logic [CNW-1:0]       r_count;

    // Output register.
    logic                 r_out_valid;
    logic                 r_out_hit;
    logic [IW-1:0]        r_out_idx;
    logic                 r_out_last;
    logic [CNW-1:0]       r_out_count;

    // Control decode.
    logic                 tab_we;
    logic [AW-1:0]        tab_waddr;
    logic [TW-1:0]        tab_wdata;
    logic                 scan_issue;
    logic                 scan_done;
    logic                 q_load;
    logic                 cnt_clear;
    logic                 rd_issue;
    logic                 move;
    logic                 nohit_load;
    logic                 emit_done;
    logic                 clearing;
    logic                 out_free;

    // Field views.
    logic signed [CW-1:0] c_x;
    logic signed [CW-1:0] c_y;
    logic [AW+IW-1:0]     widx_ext;
    logic signed [CW-1:0] a_x;
    logic signed [CW-1:0] a_y;
    logic                 a_en;
    logic                 a_excl;
    logic [AW+IW-1:0]     b_idx_ext;
    logic [IW-1:0]        b_idx6;
    logic                 buf_room;

    // Overlap test.
    logic signed [EW-1:0] b_w_s;
    logic signed [EW-1:0] b_h_s;
    logic signed [EW-1:0] b_er;
    logic signed [EW-1:0] b_eb;
    logic                 overlap;
    logic                 test_now;
    logic                 hit_now;
    logic                 kill;

    assign c_x       = i_pld[P_X +: CW];
    assign c_y       = i_pld[P_Y +: CW];
    assign widx_ext  = {{AW{1'b0}}, i_ctl.entry_idx};
    assign a_x       = r_tab_q[T_X +: CW];
    assign a_y       = r_tab_q[T_Y +: CW];
    assign a_en      = r_tab_q[0];
    assign a_excl    = r_excl_en &&
                       ({{IW{1'b0}}, r_a_idx} == {{AW{1'b0}}, r_excl_idx});
    assign b_idx_ext = {{IW{1'b0}}, r_b_idx};
    assign b_idx6    = b_idx_ext[IW-1:0];
    assign buf_room  = (r_n < NW'(aots_pkg::MAX_RESULTS));
    assign out_free  = !r_out_valid || !i_out_stall;

    // Overlap of the entry in the last scan stage with the query box.
    always_comb begin
        b_w_s    = EW'(r_b_w);
        b_h_s    = EW'(r_b_h);
        b_er     = r_b_ex + b_w_s;
        b_eb     = r_b_ey + b_h_s;
        overlap  = (r_qr > r_b_ex) && (r_qx < b_er) &&
                   (r_qb > r_b_ey) && (r_qy < b_eb);
        test_now = (r_state == aots_pkg::ST_SCAN) && r_b_test;
        hit_now  = test_now && overlap;
        kill     = hit_now && !i_report_all;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            aots_pkg::ST_CLEAR: begin
                if (r_ptr == PW'(TABLE_DEPTH - 1)) n_state = aots_pkg::ST_IDLE;
            end
            aots_pkg::ST_IDLE: begin
                if (i_cmd_valid && (i_ctl.op == aots_pkg::OP_QUERY)) begin
                    n_state = aots_pkg::ST_SCAN;
                end
            end
            aots_pkg::ST_SCAN: begin
                if (scan_done) n_state = aots_pkg::ST_EMIT;
            end
            aots_pkg::ST_EMIT: begin
                if (emit_done) n_state = aots_pkg::ST_IDLE;
            end
        endcase
    end

    // Per-state control.
    always_comb begin
        o_cmd_pop  = 1'b0;
        tab_we     = 1'b0;
        tab_waddr  = r_ptr[AW-1:0];
        tab_wdata  = '0;
        scan_issue = 1'b0;
        scan_done  = 1'b0;
        q_load     = 1'b0;
        cnt_clear  = 1'b0;
        rd_issue   = 1'b0;
        move       = 1'b0;
        nohit_load = 1'b0;
        emit_done  = 1'b0;
        clearing   = 1'b0;
        unique case (r_state)
            aots_pkg::ST_CLEAR: begin
                clearing = 1'b1;
                tab_we   = 1'b1;
            end
            aots_pkg::ST_IDLE: begin
                o_cmd_pop = i_cmd_valid;
                if (i_cmd_valid) begin
                    unique case (i_ctl.op)
                        aots_pkg::OP_WRITE: begin
                            tab_we    = 1'b1;
                            tab_waddr = widx_ext[AW-1:0];
                            tab_wdata = {c_x, c_y, i_pld[P_W +: DW], i_pld[P_H +: DW],
                                         i_ctl.entry_en};
                        end
                        aots_pkg::OP_QUERY: begin
                            q_load = 1'b1;
                        end
                        aots_pkg::OP_CLEAR: begin
                            cnt_clear = 1'b1;
                        end
                        default: begin
                            cnt_clear = 1'b0;
                        end
                    endcase
                end
            end
            aots_pkg::ST_SCAN: begin
                scan_issue = !kill && (r_ptr != PW'(TABLE_DEPTH));
                scan_done  = kill || ((r_ptr == PW'(TABLE_DEPTH)) && !r_a_vld);
            end
            aots_pkg::ST_EMIT: begin
                move = r_rd_vld && out_free;
                if (r_n == '0) begin
                    nohit_load = out_free;
                    emit_done  = out_free;
                end else begin
                    rd_issue  = (r_rd_ptr != r_n) && (!r_rd_vld || move);
                    emit_done = (r_rd_ptr == r_n) && (!r_rd_vld || move);
                end
            end
        endcase
    end

    assign o_clearing = clearing;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= aots_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Table memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (tab_we) begin
            r_tab[tab_waddr] <= tab_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (scan_issue) begin
            r_tab_q <= r_tab[r_ptr[AW-1:0]];
        end
    end

    // Table pointer: sweeps the clear pass after reset, then each scan.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
        end else if (q_load) begin
            r_ptr <= '0;
        end else if (clearing || scan_issue) begin
            r_ptr <= r_ptr + PW'(1);
        end
    end

    // Scan pipeline valids; a first-mode hit flushes what is in flight.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld  <= 1'b0;
            r_b_test <= 1'b0;
        end else begin
            r_a_vld  <= scan_issue;
            r_b_test <= r_a_vld && !kill && a_en && !a_excl;
        end
    end

    // Scan pipeline data: add the scroll offset to the entry position.
    always_ff @(posedge i_clk) begin
        if (scan_issue) begin
            r_a_idx <= r_ptr[AW-1:0];
        end
        r_b_idx <= r_a_idx;
        r_b_ex  <= EW'(a_x) + EW'(i_scroll_x);
        r_b_ey  <= EW'(a_y) + EW'(i_scroll_y);
        r_b_w   <= r_tab_q[T_W +: DW];
        r_b_h   <= r_tab_q[T_H +: DW];
    end

    // Query box captured when the query leaves the queue.
    always_ff @(posedge i_clk) begin
        if (q_load) begin
            r_qx       <= EW'(c_x);
            r_qy       <= EW'(c_y);
            r_qr       <= i_pld[P_QR +: EW];
            r_qb       <= i_pld[P_QB +: EW];
            r_excl_en  <= i_ctl.excl_en;
            r_excl_idx <= i_ctl.excl_idx;
        end
    end

    // Hit buffer memory.
    always_ff @(posedge i_clk) begin
        if (hit_now && buf_room) begin
            r_rbuf[r_n[BAW-1:0]] <= b_idx6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_issue) begin
            r_rd_data <= r_rbuf[r_rd_ptr[BAW-1:0]];
            r_rd_last <= (r_rd_ptr == (r_n - NW'(1)));
        end
    end

    // Hit count and readout pointer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n      <= '0;
            r_rd_ptr <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (q_load) begin
                r_n <= '0;
            end else if (hit_now && buf_room) begin
                r_n <= r_n + NW'(1);
            end
            if (q_load) begin
                r_rd_ptr <= '0;
            end else if (rd_issue) begin
                r_rd_ptr <= r_rd_ptr + NW'(1);
            end
            if (rd_issue) begin
                r_rd_vld <= 1'b1;
            end else if (move) begin
                r_rd_vld <= 1'b0;
            end
        end
    end

    // Saturating check counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (cnt_clear) begin
            r_count <= '0;
        end else if (test_now && (r_count != '1)) begin
            r_count <= r_count + CNW'(1);
        end
    end

    // Output register; the count is stable for the whole readout.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (nohit_load || move) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (nohit_load) begin
            r_out_hit   <= 1'b0;
            r_out_idx   <= '0;
            r_out_last  <= 1'b1;
            r_out_count <= r_count;
        end else if (move) begin
            r_out_hit   <= 1'b1;
            r_out_idx   <= r_rd_data;
            r_out_last  <= r_rd_last;
            r_out_count <= r_count;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_hit         = r_out_hit;
    assign o_hit_index   = r_out_idx;
    assign o_last        = r_out_last;
    assign o_check_count = r_out_count;

endmodule

`default_nettype wire

// ----- sv/aabb_overlap_table_search_core.sv -----
// A write or clear takes effect when the back pops it from the command queue; a query's
// words leave through the output register after its scan and the hit buffer readout.
// The box table has a single read port and the back pops no new command until a query's
// readout ends (a first-mode hit ends the scan early); writes and clears go one per cycle
// while the back is idle. Reset: synchronous, active low; the table is then cleared
// entry by entry with the input stalled, while the configuration port stays ready.
`timescale 1ns / 1ps
`default_nettype none

module aabb_overlap_table_search_core #(
    parameter int TABLE_DEPTH = aots_pkg::TABLE_DEPTH_DEF,
    parameter int COORD_WIDTH = aots_pkg::COORD_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input words
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [aots_pkg::REQ_W-1:0]        i_req_type,
    input  logic [aots_pkg::IDX_W-1:0]        i_entry_index,
    input  logic signed [COORD_WIDTH-1:0]     i_box_x,
    input  logic signed [COORD_WIDTH-1:0]     i_box_y,
    input  logic [aots_pkg::DIM_W-1:0]        i_box_w,
    input  logic [aots_pkg::DIM_W-1:0]        i_box_h,
    input  logic                              i_entry_enable,
    input  logic                              i_exclude_enable,
    input  logic [aots_pkg::IDX_W-1:0]        i_exclude_index,
    // Result words
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_hit,
    output logic [aots_pkg::IDX_W-1:0]        o_hit_index,
    output logic                              o_last,
    output logic [aots_pkg::CNT_W-1:0]        o_check_count,
    // Configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [aots_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [COORD_WIDTH-1:0]            i_cfg_data
);

    localparam int PLW = aots_pkg::pld_w(COORD_WIDTH);
    localparam int CTW = $bits(aots_pkg::t_ctl);
    localparam int QW  = CTW + PLW;

    logic signed [COORD_WIDTH-1:0] r_scroll_x;
    logic signed [COORD_WIDTH-1:0] r_scroll_y;
    logic                          r_report_all;

    logic                 f_push;
    aots_pkg::t_ctl       f_ctl;
    logic [PLW-1:0]       f_pld;
    logic                 q_full;
    logic                 q_empty;
    logic [QW-1:0]        q_rdata;
    aots_pkg::t_ctl       q_ctl;
    logic [PLW-1:0]       q_pld;
    logic                 b_pop;
    logic                 b_clearing;

    // Configuration registers; writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scroll_x   <= '0;
            r_scroll_y   <= '0;
            r_report_all <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                aots_pkg::CFG_SCROLL_X:   r_scroll_x   <= i_cfg_data;
                aots_pkg::CFG_SCROLL_Y:   r_scroll_y   <= i_cfg_data;
                aots_pkg::CFG_REPORT_ALL: r_report_all <= i_cfg_data[0];
                default:                  r_report_all <= r_report_all;
            endcase
        end
    end

    // Front: accept and decode requests.
    aots_front #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_req_type       (i_req_type),
        .i_entry_index    (i_entry_index),
        .i_box_x          (i_box_x),
        .i_box_y          (i_box_y),
        .i_box_w          (i_box_w),
        .i_box_h          (i_box_h),
        .i_entry_enable   (i_entry_enable),
        .i_exclude_enable (i_exclude_enable),
        .i_exclude_index  (i_exclude_index),
        .i_full           (q_full),
        .i_hold           (b_clearing),
        .o_push           (f_push),
        .o_ctl            (f_ctl),
        .o_pld            (f_pld)
    );

    // Command queue between front and back.
    aots_fifo #(
        .WIDTH (QW),
        .DEPTH (aots_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_wdata ({f_ctl, f_pld}),
        .o_full  (q_full),
        .i_pop   (b_pop),
        .o_rdata (q_rdata),
        .o_empty (q_empty)
    );

    assign q_ctl = aots_pkg::t_ctl'(q_rdata[QW-1 -: CTW]);
    assign q_pld = q_rdata[PLW-1:0];

    // Back: table, scan and result readout.
    aots_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (!q_empty),
        .o_cmd_pop     (b_pop),
        .i_ctl         (q_ctl),
        .i_pld         (q_pld),
        .i_scroll_x    (r_scroll_x),
        .i_scroll_y    (r_scroll_y),
        .i_report_all  (r_report_all),
        .o_clearing    (b_clearing),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_hit         (o_hit),
        .o_hit_index   (o_hit_index),
        .o_last        (o_last),
        .o_check_count (o_check_count)
    );

endmodule

`default_nettype wire

// ----- tb/aots_hit_checker.sv -----
`timescale 1ns / 1ps

// Watches the request, result and register channels of the box search core,
// keeps its own copy of the box table and registers, and checks every result word.
module aots_hit_checker #(
    parameter int DEPTH = aots_pkg::TABLE_DEPTH_DEF,
    parameter int CW    = aots_pkg::COORD_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Request channel
    input  logic                               i_in_valid,
    input  logic                               i_in_stall,
    input  logic [aots_pkg::REQ_W-1:0]         i_req_type,
    input  logic [aots_pkg::IDX_W-1:0]         i_entry_index,
    input  logic signed [CW-1:0]               i_box_x,
    input  logic signed [CW-1:0]               i_box_y,
    input  logic [aots_pkg::DIM_W-1:0]         i_box_w,
    input  logic [aots_pkg::DIM_W-1:0]         i_box_h,
    input  logic                               i_entry_enable,
    input  logic                               i_exclude_enable,
    input  logic [aots_pkg::IDX_W-1:0]         i_exclude_index,
    // Result channel
    input  logic                               i_out_valid,
    input  logic                               i_out_stall,
    input  logic                               i_hit,
    input  logic [aots_pkg::IDX_W-1:0]         i_hit_index,
    input  logic                               i_last,
    input  logic [aots_pkg::CNT_W-1:0]         i_check_count,
    // Register channel
    input  logic                               i_cfg_valid,
    input  logic                               i_cfg_ready,
    input  logic [aots_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CW-1:0]                      i_cfg_data,
    // Status for the top
    output int                                 o_mismatch_count,
    output int                                 o_pending
);
    import aots_pkg::*;

    typedef struct {
        logic             hit;
        logic [IDX_W-1:0] index;
        logic             last;
        logic [CNT_W-1:0] count;
    } t_hit_word;

    // Shadow of the box table and of the registers.
    logic signed [CW-1:0] box_left [DEPTH];
    logic signed [CW-1:0] box_top  [DEPTH];
    logic [DIM_W-1:0]     box_wid  [DEPTH];
    logic [DIM_W-1:0]     box_hgt  [DEPTH];
    logic                 box_on   [DEPTH];
    logic signed [CW-1:0] scroll_x;
    logic signed [CW-1:0] scroll_y;
    logic                 report_all;
    logic [CNT_W-1:0]     tests_done;

    t_hit_word expected_hits[$];
    int        mismatches;

    initial begin
        o_mismatch_count = 0;
        o_pending = 0;
        mismatches = 0;
    end

    // Scans the shadow table the way the core does and queues the words it should give.
    task automatic scan_table(input logic signed [CW-1:0] qx, input logic signed [CW-1:0] qy,
                              input logic [DIM_W-1:0] qw, input logic [DIM_W-1:0] qh,
                              input logic excl_en, input logic [IDX_W-1:0] excl_idx);
        longint    ex, ey, qxl, qyl;
        t_hit_word found[$];
        t_hit_word word;
        qxl = longint'(qx);
        qyl = longint'(qy);
        for (int i = 0; i < DEPTH; i++) begin
            if (!box_on[i] || (excl_en && i == int'(excl_idx)))
                continue;
            if (tests_done != '1)
                tests_done++;
            ex = longint'(box_left[i]) + longint'(scroll_x);
            ey = longint'(box_top[i]) + longint'(scroll_y);
            // Strict overlap on both axes; edges that only touch do not overlap.
            if (qxl + longint'(qw) > ex && qxl < ex + longint'(box_wid[i]) &&
                qyl + longint'(qh) > ey && qyl < ey + longint'(box_hgt[i])) begin
                if (found.size() < MAX_RESULTS) begin
                    word.hit = 1'b1;
                    word.index = IDX_W'(i);
                    word.last = 1'b0;
                    word.count = '0;
                    found.insert(found.size(), word);
                end
                if (!report_all)
                    break;
            end
        end
        if (found.size() == 0) begin
            word.hit = 1'b0;
            word.index = '0;
            word.last = 1'b1;
            word.count = tests_done;
            expected_hits.insert(expected_hits.size(), word);
        end else begin
            // Every word carries the count after the whole scan.
            found[found.size() - 1].last = 1'b1;
            foreach (found[k]) begin
                found[k].count = tests_done;
                expected_hits.insert(expected_hits.size(), found[k]);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_hit_word want;
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                box_left[i] = '0;
                box_top[i] = '0;
                box_wid[i] = '0;
                box_hgt[i] = '0;
                box_on[i] = 1'b0;
            end
            scroll_x = '0;
            scroll_y = '0;
            report_all = 1'b0;
            tests_done = '0;
            expected_hits.delete();
        end else begin
            // Compare each accepted result word with the oldest expected one.
            if (i_out_valid && !i_out_stall) begin
                if (expected_hits.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected word: hit=%0d index=%0d last=%0d count=%0d",
                                 $time, i_hit, i_hit_index, i_last, i_check_count);
                end else begin
                    want = expected_hits.pop_front();
                    if (i_hit !== want.hit || i_hit_index !== want.index ||
                        i_last !== want.last || i_check_count !== want.count) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $write("%0t: mismatch: expected hit=%0d index=%0d last=%0d count=%0d,",
                                   $time, want.hit, want.index, want.last, want.count);
                            $display(" got hit=%0d index=%0d last=%0d count=%0d",
                                     i_hit, i_hit_index, i_last, i_check_count);
                        end
                    end
                end
            end

            // Register writes.
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SCROLL_X:   scroll_x = signed'(i_cfg_data);
                    CFG_SCROLL_Y:   scroll_y = signed'(i_cfg_data);
                    CFG_REPORT_ALL: report_all = i_cfg_data[0];
                    default: ;
                endcase
            end

            // Accepted request words; unused codes change nothing.
            if (i_in_valid && !i_in_stall) begin
                case (i_req_type)
                    REQ_WRITE: begin
                        if (int'(i_entry_index) < DEPTH) begin
                            box_left[i_entry_index] = i_box_x;
                            box_top[i_entry_index] = i_box_y;
                            box_wid[i_entry_index] = i_box_w;
                            box_hgt[i_entry_index] = i_box_h;
                            box_on[i_entry_index] = i_entry_enable;
                        end
                    end
                    REQ_QUERY: scan_table(i_box_x, i_box_y, i_box_w, i_box_h,
                                          i_exclude_enable, i_exclude_index);
                    REQ_CLEAR: tests_done = '0;
                    default: ;
                endcase
            end
        end
        o_pending <= expected_hits.size();
        o_mismatch_count <= mismatches;
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import aots_pkg::*;

    localparam int DEPTH = TABLE_DEPTH_DEF;
    localparam int CW = COORD_WIDTH_DEF;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 16;
    localparam int MIN_C = -32768;
    localparam int MAX_C = 32767;
    localparam int MAX_DIM = 32767;

    typedef enum int {
        STALL_NONE,
        STALL_SOME,
        STALL_HEAVY
    } t_stall_mode;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [REQ_W-1:0]       req_type = REQ_WRITE;
    logic [IDX_W-1:0]       entry_index = '0;
    logic signed [CW-1:0]   box_x = '0;
    logic signed [CW-1:0]   box_y = '0;
    logic [DIM_W-1:0]       box_w = '0;
    logic [DIM_W-1:0]       box_h = '0;
    logic                   entry_enable = 1'b0;
    logic                   exclude_enable = 1'b0;
    logic [IDX_W-1:0]       exclude_index = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic                   hit;
    logic [IDX_W-1:0]       hit_index;
    logic                   last;
    logic [CNT_W-1:0]       check_count;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CW-1:0]          cfg_data = '0;
    int                     mismatches;
    int                     pending;

    int                     burst_left = 0;
    int                     stall_left = 0;
    t_stall_mode            stall_mode = STALL_NONE;

    always #1 clk = ~clk;

    aabb_overlap_table_search_core dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_req_type       (req_type),
        .i_entry_index    (entry_index),
        .i_box_x          (box_x),
        .i_box_y          (box_y),
        .i_box_w          (box_w),
        .i_box_h          (box_h),
        .i_entry_enable   (entry_enable),
        .i_exclude_enable (exclude_enable),
        .i_exclude_index  (exclude_index),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_hit            (hit),
        .o_hit_index      (hit_index),
        .o_last           (last),
        .o_check_count    (check_count),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    aots_hit_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_req_type       (req_type),
        .i_entry_index    (entry_index),
        .i_box_x          (box_x),
        .i_box_y          (box_y),
        .i_box_w          (box_w),
        .i_box_h          (box_h),
        .i_entry_enable   (entry_enable),
        .i_exclude_enable (exclude_enable),
        .i_exclude_index  (exclude_index),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_hit            (hit),
        .i_hit_index      (hit_index),
        .i_last           (last),
        .i_check_count    (check_count),
        .i_cfg_valid      (cfg_valid),
        .i_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .o_mismatch_count (mismatches),
        .o_pending        (pending)
    );

    // The result side stalls in segments of random length, each with its own mood.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (stall_left == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 2));
                stall_left = $urandom_range(10, 80);
            end
            stall_left--;
            case (stall_mode)
                STALL_NONE: out_stall <= 1'b0;
                STALL_SOME: out_stall <= ($urandom_range(0, 2) == 0);
                default:    out_stall <= ($urandom_range(0, 9) < 7);
            endcase
        end
    end

    // Sends one request word; words go out in bursts with random gaps between them.
    task automatic send_word(input logic [REQ_W-1:0] req, input logic [IDX_W-1:0] idx,
                             input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                             input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                             input logic en, input logic excl_en,
                             input logic [IDX_W-1:0] excl_idx);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        in_valid <= 1'b1;
        req_type <= req;
        entry_index <= idx;
        box_x <= x;
        box_y <= y;
        box_w <= w;
        box_h <= h;
        entry_enable <= en;
        exclude_enable <= excl_en;
        exclude_index <= excl_idx;
        do @(posedge clk); while (in_stall);
    endtask

    // Holds the sender off until every expected word has come, then lets the core settle.
    task automatic wait_drained(input int tail);
        in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (pending != 0);
        repeat (tail) @(posedge clk);
    endtask

    task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input logic [CW-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_near(input int idx, input int cx, input int cy,
                              input int max_dim, input int on_pct);
        int x, y;
        x = cx + int'($urandom_range(0, 1200)) - 600;
        y = cy + int'($urandom_range(0, 1200)) - 600;
        send_word(REQ_WRITE, IDX_W'(idx), CW'(x), CW'(y),
                  DIM_W'($urandom_range(0, max_dim)), DIM_W'($urandom_range(0, max_dim)),
                  ($urandom_range(0, 99) < on_pct), 1'($urandom), IDX_W'($urandom));
    endtask

    task automatic query_near(input int cx, input int cy);
        int x, y;
        x = cx + int'($urandom_range(0, 1400)) - 700;
        y = cy + int'($urandom_range(0, 1400)) - 700;
        send_word(REQ_QUERY, IDX_W'($urandom), CW'(x), CW'(y),
                  DIM_W'($urandom_range(0, 700)), DIM_W'($urandom_range(0, 700)),
                  1'($urandom), 1'($urandom), IDX_W'($urandom));
    endtask

    // One register setting: the entries sit around one spot on the map and the
    // queries around the same spot on screen, so that overlaps are common.
    task automatic run_phase(input int sx, input int sy, input logic all, input logic fill,
                             input int n);
        int cex, cey, cqx, cqy, sent, pick;
        wait_drained(SETTLE_CYCLES);
        set_register(CFG_SCROLL_X, CW'(sx));
        set_register(CFG_SCROLL_Y, CW'(sy));
        set_register(CFG_REPORT_ALL, CW'(all));
        cex = -(sx / 2);
        cey = -(sy / 2);
        cqx = cex + sx;
        cqy = cey + sy;
        sent = 0;
        if (fill) begin
            for (int i = 0; i < DEPTH; i++)
                write_near(i, cex, cey, 1500, 90);
            sent = DEPTH;
        end
        while (sent < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                write_near($urandom_range(0, DEPTH - 1), cex, cey, 400, 80);
                sent++;
            end else if (pick < 85) begin
                query_near(cqx, cqy);
                sent++;
            end else if (pick < 94) begin
                send_word((pick < 90) ? REQ_QUERY : REQ_WRITE, IDX_W'($urandom),
                          CW'($urandom), CW'($urandom), DIM_W'($urandom), DIM_W'($urandom),
                          1'($urandom), 1'($urandom), IDX_W'($urandom));
                sent++;
            end else if (pick < 97) begin
                send_word(REQ_CLEAR, IDX_W'($urandom), CW'($urandom), CW'($urandom),
                          DIM_W'($urandom), DIM_W'($urandom), 1'($urandom), 1'($urandom),
                          IDX_W'($urandom));
                sent++;
            end else if (pick < 99) begin
                send_word(REQ_UNUSED, IDX_W'($urandom), CW'($urandom), CW'($urandom),
                          DIM_W'($urandom), DIM_W'($urandom), 1'($urandom), 1'($urandom),
                          IDX_W'($urandom));
            end else begin
                wait_drained(0);
            end
        end
    endtask

    // Run limit, far beyond the slowest correct run.
    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words on the reset settings: empty table, extreme boxes,
        // zero-size and disabled entries, edges that only touch, exclusion.
        send_word(REQ_QUERY, '0, 16'sd0, 16'sd0, 15'd10, 15'd10, 1'b0, 1'b0, '0);
        send_word(REQ_WRITE, 6'd0, CW'(MIN_C), CW'(MIN_C), DIM_W'(MAX_DIM), DIM_W'(MAX_DIM),
                  1'b1, 1'b0, '0);
        send_word(REQ_WRITE, 6'd63, CW'(MAX_C), CW'(MAX_C), DIM_W'(MAX_DIM), DIM_W'(MAX_DIM),
                  1'b1, 1'b1, '1);
        send_word(REQ_WRITE, 6'd5, 16'sd100, 16'sd100, 15'd0, 15'd10, 1'b1, 1'b0, '0);
        send_word(REQ_WRITE, 6'd6, 16'sd100, 16'sd100, 15'd10, 15'd0, 1'b1, 1'b0, '0);
        send_word(REQ_WRITE, 6'd7, 16'sd100, 16'sd100, 15'd20, 15'd20, 1'b0, 1'b0, '0);
        send_word(REQ_WRITE, 6'd10, 16'sd100, 16'sd100, 15'd20, 15'd20, 1'b1, 1'b0, '0);
        send_word(REQ_QUERY, '0, CW'(MIN_C), CW'(MIN_C), 15'd1, 15'd1, 1'b0, 1'b0, '0);
        send_word(REQ_QUERY, '1, CW'(MAX_C), CW'(MAX_C), DIM_W'(MAX_DIM), DIM_W'(MAX_DIM),
                  1'b0, 1'b0, '0);
        send_word(REQ_QUERY, '0, 16'sd105, 16'sd105, 15'd1, 15'd1, 1'b0, 1'b1, 6'd10);
        send_word(REQ_QUERY, '0, 16'sd120, 16'sd100, 15'd5, 15'd5, 1'b0, 1'b0, '0);
        send_word(REQ_QUERY, '0, 16'sd95, 16'sd95, 15'd5, 15'd5, 1'b0, 1'b0, '0);
        send_word(REQ_QUERY, '0, 16'sd119, 16'sd119, 15'd1, 15'd1, 1'b0, 1'b0, '0);
        send_word(REQ_QUERY, '0, 16'sd110, 16'sd110, 15'd0, 15'd5, 1'b0, 1'b0, '0);
        send_word(REQ_QUERY, '0, -16'sd1, -16'sd1, 15'd1, 15'd1, 1'b0, 1'b0, '0);
        send_word(REQ_UNUSED, '1, '1, '1, '1, '1, 1'b1, 1'b1, '1);
        send_word(REQ_CLEAR, '0, '0, '0, '0, '0, 1'b0, 1'b0, '0);
        send_word(REQ_QUERY, '0, CW'(MIN_C), CW'(MIN_C), DIM_W'(MAX_DIM), DIM_W'(MAX_DIM),
                  1'b0, 1'b1, 6'd63);
        send_word(REQ_QUERY, '0, CW'(MIN_C), CW'(MIN_C), DIM_W'(MAX_DIM), DIM_W'(MAX_DIM),
                  1'b0, 1'b1, 6'd0);
        send_word(REQ_QUERY, '0, CW'(MAX_C), CW'(MIN_C), DIM_W'(MAX_DIM), DIM_W'(MAX_DIM),
                  1'b0, 1'b0, '0);
        send_word(REQ_WRITE, 6'd63, '0, '0, '0, '0, 1'b0, 1'b0, '0);
        send_word(REQ_QUERY, '0, CW'(MIN_C), CW'(MIN_C), DIM_W'(MAX_DIM), DIM_W'(MAX_DIM),
                  1'b0, 1'b0, '0);

        // Random words under several register settings, extremes among them.
        run_phase(0, 0, 1'b0, 1'b0, 50);
        run_phase(0, 0, 1'b1, 1'b1, 100);
        run_phase(MAX_C, MIN_C, 1'b1, 1'b1, 100);
        run_phase(MIN_C, MAX_C, 1'b0, 1'b0, 50);
        run_phase(int'($urandom_range(0, 65535)) - 32768, int'($urandom_range(0, 65535)) - 32768,
                  1'($urandom), 1'b0, 50);

        wait_drained(DEPTH + SETTLE_CYCLES);
        @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
